### src/positional_list_engine_core_macros.svh
// Assertion macros for the positional list engine.
// Each macro expects clk and rst_n in scope.
`ifndef POSITIONAL_LIST_ENGINE_CORE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Condition holds at every clock edge out of reset.
`define PLE_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("ple assertion failed");

// Antecedent implies the consequent in the next cycle.
`define PLE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ple assertion failed");

`else

`define PLE_ASSERT_ALWAYS(lbl, cond)
`define PLE_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### src/ple_pkg.sv
package ple_pkg;

    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_APPEND = 2'd3
    } ple_func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_FULL      = 2'd2
    } ple_status_t;

    // Broadcast to every cell.
    typedef struct packed {
        logic ins;
        logic del;
    } ple_cell_op_t;

    // Decoder to top level.
    typedef struct packed {
        ple_cell_op_t op;
        logic         rd_en;
        ple_status_t  status;
    } ple_ctrl_t;

endpackage

### src/ple_cell.sv
module ple_cell
    import ple_pkg::*;
#(
    parameter int IDX = 0,
    parameter int PW  = 5,
    parameter int VW  = 32
) (
    input  logic          clk,
    input  ple_cell_op_t  op,
    input  logic [PW-1:0] pos,
    input  logic [VW-1:0] wdata,
    input  logic [VW-1:0] left_val,
    input  logic [VW-1:0] right_val,
    input  logic [VW-1:0] rd_in,
    output logic [VW-1:0] rd_out,
    output logic [VW-1:0] value
);

    localparam logic [PW-1:0] IDX_P = PW'(IDX);

    logic [VW-1:0] value_reg;
    logic [VW-1:0] value_next;
    logic          hit;
    logic          above;

    assign hit   = (pos == IDX_P);
    assign above = (IDX_P > pos);

    always_comb
    begin
        value_next = value_reg;
        if (op.ins)
        begin
            if (hit)
                value_next = wdata;
            else if (above)
                value_next = left_val;
        end
        else if (op.del)
        begin
            if (hit || above)
                value_next = right_val;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    // read-out OR chain
    assign rd_out = rd_in | (hit ? value_reg : '0);
    assign value  = value_reg;

endmodule

### src/ple_ctrl.sv
module ple_ctrl
    import ple_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int CW    = 5,
    parameter int PW    = 5
) (
    input  logic [1:0]    func,
    input  logic [4:0]    position,
    input  logic [CW-1:0] count,
    output ple_ctrl_t     ctrl,
    output logic [PW-1:0] cell_pos,
    output logic [CW-1:0] count_next
);

    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [PW-1:0] pos_x;
    logic [PW-1:0] cnt_x;
    logic          in_list;
    logic          ins_ok;
    logic          full;

    assign pos_x   = PW'(position);
    assign cnt_x   = PW'(count);
    assign in_list = (pos_x < cnt_x);
    assign ins_ok  = (pos_x <= cnt_x);
    assign full    = (count == FULL_CNT);

    always_comb
    begin
        ctrl     = '0;
        ctrl.status = ST_OK;
        cell_pos = pos_x;
        case (ple_func_t'(func))
            OP_READ:
            begin
                if (!in_list)
                    ctrl.status = ST_BAD_INDEX;
                else
                    ctrl.rd_en = 1'b1;
            end
            OP_INSERT:
            begin
                if (!ins_ok)
                    ctrl.status = ST_BAD_INDEX;
                else if (full)
                    ctrl.status = ST_FULL;
                else
                    ctrl.op.ins = 1'b1;
            end
            OP_DELETE:
            begin
                if (!in_list)
                    ctrl.status = ST_BAD_INDEX;
                else
                begin
                    ctrl.op.del = 1'b1;
                    ctrl.rd_en  = 1'b1;
                end
            end
            OP_APPEND:
            begin
                cell_pos = cnt_x;
                if (full)
                    ctrl.status = ST_FULL;
                else
                    ctrl.op.ins = 1'b1;
            end
            default:
            begin
                ctrl.status = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        if (ctrl.op.ins)
            count_next = count + CW'(1);
        else if (ctrl.op.del)
            count_next = count - CW'(1);
        else
            count_next = count;
    end

endmodule

### src/positional_list_engine_core.sv
// A request accepted on one edge has its result on the ports, with done high,
// in the following cycle.
// Throughput: one request per cycle; every entry cell updates in the same edge.
// busy never asserts, and there is no backpressure: the receiver cannot stall.
// Reset clears the entry count and the done strobe; entry cells hold no reset
// value and are only read below the count, so they need none.
`include "positional_list_engine_core_macros.svh"

module positional_list_engine_core
    import ple_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  func,
    input  logic [4:0]  position,
    input  logic [31:0] item_value,
    output logic        done,
    output logic [1:0]  status,
    output logic [31:0] read_value,
    output logic [4:0]  entry_count,
    output logic        is_empty
);

    // Count must hold DEPTH itself; positions compare in a width that holds
    // both the 5-bit request field and the count.
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > 5) ? CW : 5;

    logic            accept;
    ple_ctrl_t       ctrl;
    logic [PW-1:0]   cell_pos;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    logic [63:0]          in_wide;
    logic [VALUE_WIDTH-1:0] wdata;
    ple_cell_op_t         cell_op;

    logic [VALUE_WIDTH-1:0] cell_val [DEPTH];
    logic [VALUE_WIDTH-1:0] rd_chain [DEPTH+1];
    logic [63:0]          rd_wide;

    logic        done_reg;
    logic [1:0]  status_reg;
    logic [31:0] read_value_reg;
    logic [4:0]  entry_count_reg;
    logic        is_empty_reg;
    logic [31:0] cnt_wide;

    // Each request finishes in the cycle it is taken, so the engine is
    // always ready for the next beat.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    ple_ctrl #(
        .DEPTH (DEPTH),
        .CW    (CW),
        .PW    (PW)
    ) u_ctrl (
        .func       (func),
        .position   (position),
        .count      (count_reg),
        .ctrl       (ctrl),
        .cell_pos   (cell_pos),
        .count_next (count_next)
    );

    // Values are stored at VALUE_WIDTH; wider port bits are dropped,
    // narrower ones zero-extended.
    assign in_wide = 64'(item_value);
    assign wdata   = in_wide[VALUE_WIDTH-1:0];

    // Cells only move on an accepted beat.
    assign cell_op.ins = accept && ctrl.op.ins;
    assign cell_op.del = accept && ctrl.op.del;

    // Chain of entry cells, front of the list at cell 0. Insert shifts cells
    // above the position up from their left neighbor; delete pulls cells at
    // and above the position down from their right neighbor.
    assign rd_chain[0] = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [VALUE_WIDTH-1:0] left_v;
        logic [VALUE_WIDTH-1:0] right_v;

        if (i == 0)
        begin : g_first
            assign left_v = wdata;
        end
        else
        begin : g_mid_l
            assign left_v = cell_val[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_v = cell_val[i];
        end
        else
        begin : g_mid_r
            assign right_v = cell_val[i+1];
        end

        ple_cell #(
            .IDX (i),
            .PW  (PW),
            .VW  (VALUE_WIDTH)
        ) u_cell (
            .clk       (clk),
            .op        (cell_op),
            .pos       (cell_pos),
            .wdata     (wdata),
            .left_val  (left_v),
            .right_val (right_v),
            .rd_in     (rd_chain[i]),
            .rd_out    (rd_chain[i+1]),
            .value     (cell_val[i])
        );
    end

    // Read path: the cell at the position drives the OR chain.
    assign rd_wide  = ctrl.rd_en ? 64'(rd_chain[DEPTH]) : 64'd0;
    assign cnt_wide = 32'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
                count_reg <= count_next;
        end
    end

    // Result payload, loaded with each accepted beat.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg      <= ctrl.status;
            read_value_reg  <= rd_wide[31:0];
            entry_count_reg <= cnt_wide[4:0];
            is_empty_reg    <= (count_next == '0);
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign read_value  = read_value_reg;
    assign entry_count = entry_count_reg;
    assign is_empty    = is_empty_reg;

    // Checks
    `PLE_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(DEPTH))
    `PLE_ASSERT_NEXT(a_done_follows, accept, done)
    `PLE_ASSERT_NEXT(a_no_stray_done, !accept, !done)
    `PLE_ASSERT_NEXT(a_ins_grows, cell_op.ins, count_reg == $past(count_reg) + CW'(1))
    `PLE_ASSERT_NEXT(a_del_shrinks, cell_op.del, count_reg == $past(count_reg) - CW'(1))
    `PLE_ASSERT_ALWAYS(a_empty_flag, !done || (is_empty == (count_reg == '0)))

endmodule
